// File: src/transformed_bbox_center_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands for the bounding box center block.
// ----------------------------------------------------------------------------
`ifndef TRANSFORMED_BBOX_CENTER_DEFINES_SVH
`define TRANSFORMED_BBOX_CENTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define TBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// same-cycle implication that also holds during reset
`define TBC_ASSERT_ALWAYS(label, clk, ante, cons) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// File: src/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Widths, types, register indexes and reset values for the bbox center block.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int COORD_WIDTH    = 16;
	localparam int COEF_WIDTH     = 16;
	localparam int COEF_FRAC_BITS = 12;
	localparam int ROW_WIDTH      = 3 * COEF_WIDTH;
	localparam int RES_WIDTH      = 24;
	localparam int PROD_WIDTH     = COORD_WIDTH + COEF_WIDTH;
	localparam int SUM_WIDTH      = PROD_WIDTH + 2;
	localparam int SHIFT_WIDTH    = SUM_WIDTH - COEF_FRAC_BITS;
	localparam int ADD_WIDTH      = RES_WIDTH + 1;
	localparam int CFG_IDX_WIDTH  = 4;
	localparam int CFG_DATA_WIDTH = ROW_WIDTH;
	localparam int NUM_AXES       = 3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [RES_WIDTH-1:0]   res_t;
	typedef logic [ROW_WIDTH-1:0]          row_t;

	localparam res_t RES_MAX = {1'b0, {(RES_WIDTH-1){1'b1}}};
	localparam res_t RES_MIN = {1'b1, {(RES_WIDTH-1){1'b0}}};

	// identity rows: 1.0 on the diagonal
	localparam row_t COEF_ONE    = row_t'(1) << COEF_FRAC_BITS;
	localparam row_t ROW_X_RESET = COEF_ONE;
	localparam row_t ROW_Y_RESET = COEF_ONE << COEF_WIDTH;
	localparam row_t ROW_Z_RESET = COEF_ONE << (2 * COEF_WIDTH);

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_ROW_X    = 4'd0,
		CFG_ROW_Y    = 4'd1,
		CFG_ROW_Z    = 4'd2,
		CFG_OFFSET_X = 4'd3,
		CFG_OFFSET_Y = 4'd4,
		CFG_OFFSET_Z = 4'd5
	} cfg_idx_t;

	// load strobes for the transform stages
	typedef struct packed {
		logic ld2;
		logic ld3;
	} stage_ctl_t;

endpackage

// File: src/tbc_xform_axis.sv
// ----------------------------------------------------------------------------
// tbc_xform_axis
// One output axis of the affine transform: products, sum, shift, offset, clamp.
// ----------------------------------------------------------------------------
module tbc_xform_axis (
	input  logic                clk,
	input  tbc_pkg::stage_ctl_t ctl,
	input  tbc_pkg::row_t       row,
	input  tbc_pkg::res_t       offset,
	input  tbc_pkg::coord_t     x_s1,
	input  tbc_pkg::coord_t     y_s1,
	input  tbc_pkg::coord_t     z_s1,
	output tbc_pkg::res_t       res_s3
);

	localparam int CW = tbc_pkg::COEF_WIDTH;

	logic signed [CW-1:0]                  c0, c1, c2;
	logic signed [tbc_pkg::PROD_WIDTH-1:0] p0_s2, p1_s2, p2_s2;
	logic signed [tbc_pkg::SUM_WIDTH-1:0]  sum;
	logic signed [tbc_pkg::SHIFT_WIDTH-1:0] shifted;
	logic signed [tbc_pkg::ADD_WIDTH-1:0]  wide;
	tbc_pkg::res_t                         clamped;

	assign c0 = $signed(row[CW-1:0]);
	assign c1 = $signed(row[2*CW-1:CW]);
	assign c2 = $signed(row[3*CW-1:2*CW]);

	// stage 2: one multiply per coordinate
	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			p0_s2 <= c0 * x_s1;
			p1_s2 <= c1 * y_s1;
			p2_s2 <= c2 * z_s1;
		end
	end

	// stage 3: exact sum, floor shift, offset, saturate
	always_comb begin
		sum = tbc_pkg::SUM_WIDTH'(p0_s2) + tbc_pkg::SUM_WIDTH'(p1_s2)
			+ tbc_pkg::SUM_WIDTH'(p2_s2);
		shifted = $signed(sum[tbc_pkg::SUM_WIDTH-1:tbc_pkg::COEF_FRAC_BITS]);
		wide = tbc_pkg::ADD_WIDTH'(shifted) + tbc_pkg::ADD_WIDTH'(offset);
		if (wide[tbc_pkg::ADD_WIDTH-1] != wide[tbc_pkg::ADD_WIDTH-2]) begin
			clamped = wide[tbc_pkg::ADD_WIDTH-1] ? tbc_pkg::RES_MIN : tbc_pkg::RES_MAX;
		end else begin
			clamped = wide[tbc_pkg::RES_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld3) begin
			res_s3 <= clamped;
		end
	end

endmodule

// File: src/transformed_bbox_center.sv
// ----------------------------------------------------------------------------
// transformed_bbox_center
// Affine-transforms a vertex stream and reports the center of its bounding box.
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       x, y, z; tlast = last vertex
// m_axis    out        m_axis_tvalid/tready       center x, y, z
// cfg       in         cfg_valid/cfg_ready        register index, write data
//
// One vertex word is taken per cycle while s_axis_tready is high. A vertex
// passes the input, products, transform and tracking stages in order; a
// center word is registered at the output from the finished box of the
// tracking stage. Reset clears the box and loads the identity transform.
// A stalled output holds its word; vertices not marked last keep flowing
// while a center word waits, and a second center waits in its own stage.
// ----------------------------------------------------------------------------
module transformed_bbox_center (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [47:0]                          s_axis_tdata, // vert_x, vert_y, vert_z
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [71:0]                          m_axis_tdata, // center_x, center_y, center_z
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tbc_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [tbc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

	localparam int N  = tbc_pkg::NUM_AXES;
	localparam int RW = tbc_pkg::RES_WIDTH;
	localparam int XW = tbc_pkg::COORD_WIDTH;

	tbc_pkg::row_t       row_q  [N];
	tbc_pkg::res_t       offs_q [N];
	tbc_pkg::coord_t     x_s1, y_s1, z_s1;
	logic                v_s1, v_s2, v_s3, v_s4, m_valid_q;
	logic                last_s1, last_s2, last_s3;
	logic                empty_q;
	tbc_pkg::res_t       tr_s3 [N];
	tbc_pkg::res_t       lo_q  [N];
	tbc_pkg::res_t       hi_q  [N];
	tbc_pkg::res_t       nlo   [N];
	tbc_pkg::res_t       nhi   [N];
	tbc_pkg::res_t       lo_s4 [N];
	tbc_pkg::res_t       hi_s4 [N];
	tbc_pkg::res_t       ctr   [N];
	logic [71:0]         m_data_q;
	tbc_pkg::stage_ctl_t ctl;
	logic                out_free, take4, s4_free, cons3, s3_free, s2_free, s1_free;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]  <= tbc_pkg::ROW_X_RESET;
			row_q[1]  <= tbc_pkg::ROW_Y_RESET;
			row_q[2]  <= tbc_pkg::ROW_Z_RESET;
			offs_q[0] <= '0;
			offs_q[1] <= '0;
			offs_q[2] <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tbc_pkg::CFG_ROW_X:    row_q[0]  <= cfg_data;
				tbc_pkg::CFG_ROW_Y:    row_q[1]  <= cfg_data;
				tbc_pkg::CFG_ROW_Z:    row_q[2]  <= cfg_data;
				tbc_pkg::CFG_OFFSET_X: offs_q[0] <= cfg_data[RW-1:0];
				tbc_pkg::CFG_OFFSET_Y: offs_q[1] <= cfg_data[RW-1:0];
				tbc_pkg::CFG_OFFSET_Z: offs_q[2] <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	// stage flow: a stage loads when empty or when it moves on
	assign out_free      = !m_valid_q || m_axis_tready;
	assign take4         = v_s4 && out_free;
	assign s4_free       = !v_s4 || out_free;
	assign cons3         = v_s3 && (!last_s3 || s4_free);
	assign s3_free       = !v_s3 || cons3;
	assign s2_free       = !v_s2 || s3_free;
	assign s1_free       = !v_s1 || s2_free;
	assign s_axis_tready = s1_free;
	assign ctl.ld2       = s2_free;
	assign ctl.ld3       = s3_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1    <= s_axis_tvalid;
				last_s1 <= s_axis_tlast;
			end
			if (s2_free) begin
				v_s2    <= v_s1;
				last_s2 <= last_s1;
			end
			if (s3_free) begin
				v_s3    <= v_s2;
				last_s3 <= last_s2;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s1_free) begin
			x_s1 <= $signed(s_axis_tdata[XW-1:0]);
			y_s1 <= $signed(s_axis_tdata[2*XW-1:XW]);
			z_s1 <= $signed(s_axis_tdata[3*XW-1:2*XW]);
		end
	end

	for (genvar a = 0; a < N; a++) begin : g_axis
		tbc_xform_axis u_xform (
			.clk    (clk),
			.ctl    (ctl),
			.row    (row_q[a]),
			.offset (offs_q[a]),
			.x_s1   (x_s1),
			.y_s1   (y_s1),
			.z_s1   (z_s1),
			.res_s3 (tr_s3[a])
		);
	end

	// box tracking: first vertex seeds both bounds
	always_comb begin
		for (int a = 0; a < N; a++) begin
			if (empty_q) begin
				nlo[a] = tr_s3[a];
				nhi[a] = tr_s3[a];
			end else begin
				nlo[a] = (tr_s3[a] < lo_q[a]) ? tr_s3[a] : lo_q[a];
				nhi[a] = (tr_s3[a] > hi_q[a]) ? tr_s3[a] : hi_q[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
			v_s4    <= 1'b0;
			for (int a = 0; a < N; a++) begin
				lo_q[a] <= '0;
				hi_q[a] <= '0;
			end
		end else begin
			// a closing mesh refills the stage in the cycle it drains
			if (cons3 && last_s3) begin
				v_s4 <= 1'b1;
			end else if (take4) begin
				v_s4 <= 1'b0;
			end
			if (cons3) begin
				if (last_s3) begin
					empty_q <= 1'b1;
					for (int a = 0; a < N; a++) begin
						lo_q[a] <= '0;
						hi_q[a] <= '0;
					end
				end else begin
					empty_q <= 1'b0;
					for (int a = 0; a < N; a++) begin
						lo_q[a] <= nlo[a];
						hi_q[a] <= nhi[a];
					end
				end
			end
		end
	end

	// finished box waits here for the output register
	always_ff @(posedge clk) begin
		if (cons3 && last_s3) begin
			for (int a = 0; a < N; a++) begin
				lo_s4[a] <= nlo[a];
				hi_s4[a] <= nhi[a];
			end
		end
	end

	// center: floor of half sum
	always_comb begin
		for (int a = 0; a < N; a++) begin
			ctr[a] = tbc_pkg::res_t'((tbc_pkg::ADD_WIDTH'(lo_s4[a])
				+ tbc_pkg::ADD_WIDTH'(hi_s4[a])) >>> 1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (take4) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take4) begin
			m_data_q <= {ctr[2], ctr[1], ctr[0]};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// File: src/tbc_port_checker.sv
// ----------------------------------------------------------------------------
// tbc_port_checker
// Port-level checks for the bbox center block, bound to its top level.
// ----------------------------------------------------------------------------
`include "transformed_bbox_center_defines.svh"

module tbc_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata
);

	// a waiting center word stays and holds
	`TBC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// with the output free nothing upstream can be stalled
	`TBC_ASSERT_IMPLY(a_in_ready, clk, arst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready)

	// reset empties the pipe and opens the input
	`TBC_ASSERT_ALWAYS(a_reset_clear, clk, !arst_n, !m_axis_tvalid && s_axis_tready)

endmodule

bind transformed_bbox_center tbc_port_checker u_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
